@@ hw/rtl/cacr_pkg.sv @@
// Shared types, widths, codes and the CORDIC arctangent table for the chord-angle
// circle radius block.
// No dependencies; every other file of the block imports this package.
package cacr_pkg;

   // Point coordinates, signed Q16.16.
   localparam int COORD_WIDTH = 32;
   localparam int CORDIC_STAGES_DEF = 16;

   // Configuration register widths and the configuration port.
   localparam int WIDTH_PX_W = 13;
   localparam int FOV_W = 15;
   localparam int OFFSET_W = 14;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FOV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_UNDEF = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   // CORDIC word and angle constants in Q2.29.
   localparam int CS_W = 32;
   localparam int THETA_W = 30;
   localparam logic [CS_W-1:0] PI_Q29 = 32'd1686629713;
   localparam logic [THETA_W-1:0] HALF_PI_Q29 = 30'd843314857;
   localparam logic [CS_W-1:0] CORDIC_X0 = 32'd536870912;

   // Chord datapath widths.
   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int SQ_W = 2 * MAG_W;
   localparam int HALF_W = (MAG_W + 1) / 2;
   localparam int PP_W = 2 * HALF_W;
   localparam int ROOT_REM_W = MAG_W + 3;

   // Ratio datapath widths.
   localparam int AB_W = 45;
   localparam int NORM_W = 31;
   localparam int SH_MAX = AB_W - NORM_W;
   localparam int SH_W = 4;
   localparam int SQN_W = 2 * NORM_W;
   localparam int N_W = SQN_W + 1;
   localparam int DEN_W = SQN_W + 2;
   localparam int N_LO_W = 32;
   localparam int MP_W = HALF_W + N_LO_W;

   // Product and quotient widths.
   localparam int Q_W = 32;
   localparam int PROD_W = MAG_W + N_W;
   localparam int UPPER_W = PROD_W - Q_W;
   localparam int CMP_W = (UPPER_W > DEN_W) ? UPPER_W : DEN_W;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_z;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic [Q_W-1:0] radius;
      logic [1:0]     status;
   } rsp_type;

   typedef struct packed {
      logic signed [CS_W-1:0] x;
      logic signed [CS_W-1:0] y;
      logic signed [CS_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [MAG_W-1:0]      dx_mag;
      logic [MAG_W-1:0]      dz_mag;
      logic [WIDTH_PX_W-1:0] width_px;
      logic [OFFSET_W-1:0]   offset_px;
      logic                  flip;
      logic                  cfg_undef;
   } front_type;

   typedef struct packed {
      logic undef;
      logic neg;
      logic ab_zero;
      logic chord_zero;
      logic ovf;
   } flag_type;

   typedef struct packed {
      logic [SQ_W-1:0]       rad;
      logic [ROOT_REM_W-1:0] rem;
      logic [MAG_W-1:0]      root;
   } root_type;

   typedef struct packed {
      logic [N_W-1:0]   n;
      logic [DEN_W-1:0] den;
      flag_type         flags;
   } mid_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   low_bits;
      logic [Q_W-1:0]   quo;
   } div_type;

   typedef struct packed {
      logic [DEN_W-1:0] den;
      flag_type         flags;
   } tail_type;

   // atan(2^-i) in Q2.29, rounded to nearest.
   function automatic logic signed [CS_W-1:0] atan_q29(input int idx);
      logic signed [CS_W-1:0] val;
      case (idx)
         0: val = 32'sd421657428;
         1: val = 32'sd248918915;
         2: val = 32'sd131521918;
         3: val = 32'sd66762579;
         4: val = 32'sd33510843;
         5: val = 32'sd16771758;
         6: val = 32'sd8387925;
         7: val = 32'sd4194219;
         8: val = 32'sd2097141;
         9: val = 32'sd1048575;
         10: val = 32'sd524288;
         default: begin
            if (idx <= 29) val = 32'sd1 <<< (29 - idx);
            else val = '0;
         end
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/chord_angle_circle_radius.sv @@
// Chord-angle circle radius: radius = (chord/2) / sin(alpha), pipelined.
// Depends on cacr_pkg, cacr_cordic_cell, cacr_root_cell and cacr_div_cell.
//
// Usage:
//   Configuration words go in on the csr_ channel (csr_index selects screen width,
//   field of view or target offset); csr_ready is always high. Write them only
//   while no item is in flight.
//   A point-pair word is taken on req_data at each rising edge where start is high
//   and busy is low. busy is high while reset is held and in the first cycle after
//   it, so from then on a new word can be taken in every cycle.
//   Each result word appears on rsp_data for exactly one cycle, marked by
//   rsp_valid. With the default 16 CORDIC stages the pipeline holds
//   1 input register, one cell per CORDIC stage, 5 ratio stages,
//   33 square-root cells, 3 product stages, 32 divider cells and the output
//   register. Throughput is one word per cycle.
//   Reset clears the configuration registers and drops every word in flight.
//   The receiver cannot hold results off, so nothing here ever stalls.
//   status reads 0 for a valid radius, 1 when the angle is undefined and 2 when
//   the radius saturates; radius is all ones whenever status is not 0.
module chord_angle_circle_radius import cacr_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int LATENCY = 1 + CORDIC_STAGES + 5 + MAG_W + 3 + Q_W + 1;

   // Configuration registers.
   logic [WIDTH_PX_W-1:0] width_ff;
   logic [FOV_W-1:0]      fov_ff;
   logic [OFFSET_W-1:0]   offset_ff;
   logic                  busy_ff;

   assign csr_ready = 1'b1;
   // A word offered while reset is high would be dropped, so busy covers it.
   assign busy = busy_ff || reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
         fov_ff <= '0;
         offset_ff <= '0;
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH: width_ff <= csr_data[WIDTH_PX_W-1:0];
               REG_FOV: fov_ff <= csr_data[FOV_W-1:0];
               REG_OFFSET: offset_ff <= csr_data[OFFSET_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Input stage: coordinate differences and the folded half angle.
   logic                  s0_valid_ff;
   cordic_type            s0_rot_ff, s0_rot_in;
   front_type             s0_front_ff, s0_front_in;
   logic signed [MAG_W-1:0] dx, dz;
   logic [OFFSET_W-1:0]   offset_mag;
   logic [THETA_W-1:0]    theta;

   always_comb begin
      dx = {req_data.first_x[COORD_WIDTH-1], req_data.first_x}
         - {req_data.second_x[COORD_WIDTH-1], req_data.second_x};
      dz = {req_data.first_z[COORD_WIDTH-1], req_data.first_z}
         - {req_data.second_z[COORD_WIDTH-1], req_data.second_z};
      offset_mag = offset_ff[OFFSET_W-1] ? (~offset_ff + 1'b1) : offset_ff;
      theta = {fov_ff, 15'b0};
      s0_front_in.dx_mag = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      s0_front_in.dz_mag = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
      s0_front_in.width_px = width_ff;
      s0_front_in.offset_px = offset_mag;
      s0_front_in.flip = theta > HALF_PI_Q29;
      s0_front_in.cfg_undef = (width_ff == '0) || (offset_mag == '0) || (fov_ff == '0);
      // Beyond a quarter turn the rotation runs on pi minus the angle.
      s0_rot_in.x = CORDIC_X0;
      s0_rot_in.y = '0;
      s0_rot_in.z = s0_front_in.flip ? PI_Q29 - CS_W'(theta) : CS_W'(theta);
   end

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else s0_valid_ff <= start && !busy_ff;
      s0_rot_ff <= s0_rot_in;
      s0_front_ff <= s0_front_in;
   end

   // CORDIC row.
   logic       cor_valid [CORDIC_STAGES+1];
   cordic_type cor_rot [CORDIC_STAGES+1];
   front_type  cor_front [CORDIC_STAGES+1];

   assign cor_valid[0] = s0_valid_ff;
   assign cor_rot[0] = s0_rot_ff;
   assign cor_front[0] = s0_front_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      cacr_cordic_cell #(.STAGE(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (cor_valid[i]),
         .in_rot   (cor_rot[i]),
         .in_front (cor_front[i]),
         .out_valid(cor_valid[i+1]),
         .out_rot  (cor_rot[i+1]),
         .out_front(cor_front[i+1])
      );
   end

   // Stage A: sign checks, A and B products, partial squares of the differences.
   cordic_type rot_end;
   front_type  front_end;
   logic signed [CS_W-1:0] cos_v, sin_v;
   logic [HALF_W-1:0] dx_hi, dx_lo, dz_hi, dz_lo;

   logic            sa_valid_ff;
   flag_type        sa_flags_ff, sa_flags_in;
   logic [AB_W-1:0] sa_a_ff, sa_a_in, sa_b_ff, sa_b_in;
   logic [PP_W-1:0] sa_xhh_ff, sa_xhh_in, sa_xhl_ff, sa_xhl_in, sa_xll_ff, sa_xll_in;
   logic [PP_W-1:0] sa_zhh_ff, sa_zhh_in, sa_zhl_ff, sa_zhl_in, sa_zll_ff, sa_zll_in;

   always_comb begin
      rot_end = cor_rot[CORDIC_STAGES];
      front_end = cor_front[CORDIC_STAGES];
      cos_v = front_end.flip ? -rot_end.x : rot_end.x;
      sin_v = rot_end.y;
      sa_flags_in.undef = front_end.cfg_undef || (cos_v == '0) || (sin_v == '0);
      sa_flags_in.neg = cos_v[CS_W-1] || sin_v[CS_W-1];
      sa_flags_in.ab_zero = 1'b0;
      sa_flags_in.chord_zero = 1'b0;
      sa_flags_in.ovf = 1'b0;
      sa_a_in = AB_W'(front_end.width_px) * AB_W'(cos_v[NORM_W-1:0]);
      sa_b_in = AB_W'(front_end.offset_px) * AB_W'(sin_v[NORM_W-1:0]);
      dx_hi = HALF_W'(front_end.dx_mag >> HALF_W);
      dx_lo = front_end.dx_mag[HALF_W-1:0];
      dz_hi = HALF_W'(front_end.dz_mag >> HALF_W);
      dz_lo = front_end.dz_mag[HALF_W-1:0];
      sa_xhh_in = PP_W'(dx_hi) * PP_W'(dx_hi);
      sa_xhl_in = PP_W'(dx_hi) * PP_W'(dx_lo);
      sa_xll_in = PP_W'(dx_lo) * PP_W'(dx_lo);
      sa_zhh_in = PP_W'(dz_hi) * PP_W'(dz_hi);
      sa_zhl_in = PP_W'(dz_hi) * PP_W'(dz_lo);
      sa_zll_in = PP_W'(dz_lo) * PP_W'(dz_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) sa_valid_ff <= 1'b0;
      else sa_valid_ff <= cor_valid[CORDIC_STAGES];
      sa_flags_ff <= sa_flags_in;
      sa_a_ff <= sa_a_in;
      sa_b_ff <= sa_b_in;
      sa_xhh_ff <= sa_xhh_in;
      sa_xhl_ff <= sa_xhl_in;
      sa_xll_ff <= sa_xll_in;
      sa_zhh_ff <= sa_zhh_in;
      sa_zhl_ff <= sa_zhl_in;
      sa_zll_ff <= sa_zll_in;
   end

   // Stage B: chord squared, and the common shift that brings A and B below 2^31.
   logic            sb_valid_ff;
   flag_type        sb_flags_ff;
   logic [AB_W-1:0] sb_a_ff, sb_b_ff, ab_or;
   logic [SQ_W-1:0] sb_sq_ff, sb_sq_in;
   logic [SH_W-1:0] sb_sh_ff, sb_sh_in;

   always_comb begin
      sb_sq_in = (SQ_W'(sa_xhh_ff) << (2 * HALF_W)) + (SQ_W'(sa_xhl_ff) << (HALF_W + 1))
               + SQ_W'(sa_xll_ff)
               + (SQ_W'(sa_zhh_ff) << (2 * HALF_W)) + (SQ_W'(sa_zhl_ff) << (HALF_W + 1))
               + SQ_W'(sa_zll_ff);
      ab_or = sa_a_ff | sa_b_ff;
      sb_sh_in = SH_W'(SH_MAX);
      for (int k = SH_MAX; k >= 0; k--) begin
         if (((ab_or >> k) >> NORM_W) == '0) sb_sh_in = SH_W'(k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sb_valid_ff <= 1'b0;
      else sb_valid_ff <= sa_valid_ff;
      sb_flags_ff <= sa_flags_ff;
      sb_a_ff <= sa_a_ff;
      sb_b_ff <= sa_b_ff;
      sb_sq_ff <= sb_sq_in;
      sb_sh_ff <= sb_sh_in;
   end

   // Stage C: apply the shift.
   logic              sc_valid_ff;
   flag_type          sc_flags_ff, sc_flags_in;
   logic [NORM_W-1:0] sc_a_ff, sc_a_in, sc_b_ff, sc_b_in;
   logic [SQ_W-1:0]   sc_sq_ff;

   always_comb begin
      sc_a_in = NORM_W'(sb_a_ff >> sb_sh_ff);
      sc_b_in = NORM_W'(sb_b_ff >> sb_sh_ff);
      sc_flags_in = sb_flags_ff;
      sc_flags_in.ab_zero = (sc_a_in == '0) || (sc_b_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) sc_valid_ff <= 1'b0;
      else sc_valid_ff <= sb_valid_ff;
      sc_flags_ff <= sc_flags_in;
      sc_a_ff <= sc_a_in;
      sc_b_ff <= sc_b_in;
      sc_sq_ff <= sb_sq_ff;
   end

   // Stage D: A^2, B^2 and A*B.
   logic             sd_valid_ff;
   flag_type         sd_flags_ff;
   logic [SQN_W-1:0] sd_aa_ff, sd_bb_ff, sd_ab_ff;
   logic [SQ_W-1:0]  sd_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) sd_valid_ff <= 1'b0;
      else sd_valid_ff <= sc_valid_ff;
      sd_flags_ff <= sc_flags_ff;
      sd_aa_ff <= SQN_W'(sc_a_ff) * SQN_W'(sc_a_ff);
      sd_bb_ff <= SQN_W'(sc_b_ff) * SQN_W'(sc_b_ff);
      sd_ab_ff <= SQN_W'(sc_a_ff) * SQN_W'(sc_b_ff);
      sd_sq_ff <= sc_sq_ff;
   end

   // Stage E: numerator A^2+B^2 and denominator 4AB; square root row starts here.
   logic     se_valid_ff;
   mid_type  se_mid_ff, se_mid_in;
   root_type se_root_ff, se_root_in;

   always_comb begin
      se_mid_in.n = N_W'(sd_aa_ff) + N_W'(sd_bb_ff);
      se_mid_in.den = {sd_ab_ff, 2'b00};
      se_mid_in.flags = sd_flags_ff;
      se_root_in.rad = sd_sq_ff;
      se_root_in.rem = '0;
      se_root_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) se_valid_ff <= 1'b0;
      else se_valid_ff <= sd_valid_ff;
      se_mid_ff <= se_mid_in;
      se_root_ff <= se_root_in;
   end

   logic     rt_valid [MAG_W+1];
   root_type rt_root [MAG_W+1];
   mid_type  rt_mid [MAG_W+1];

   assign rt_valid[0] = se_valid_ff;
   assign rt_root[0] = se_root_ff;
   assign rt_mid[0] = se_mid_ff;

   for (genvar i = 0; i < MAG_W; i++) begin : g_root
      cacr_root_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (rt_valid[i]),
         .in_root  (rt_root[i]),
         .in_mid   (rt_mid[i]),
         .out_valid(rt_valid[i+1]),
         .out_root (rt_root[i+1]),
         .out_mid  (rt_mid[i+1])
      );
   end

   // Stage F: partial products of chord times numerator.
   mid_type          mid_end;
   logic [MAG_W-1:0] chord;
   logic [HALF_W-1:0] chord_hi, chord_lo;
   logic [N_LO_W-1:0] n_hi, n_lo;

   logic             sf_valid_ff;
   tail_type         sf_tail_ff, sf_tail_in;
   logic [MP_W-1:0]  sf_hh_ff, sf_hh_in, sf_hl_ff, sf_hl_in, sf_lh_ff, sf_lh_in;
   logic [MP_W-1:0]  sf_ll_ff, sf_ll_in;

   always_comb begin
      mid_end = rt_mid[MAG_W];
      chord = rt_root[MAG_W].root;
      chord_hi = HALF_W'(chord >> HALF_W);
      chord_lo = chord[HALF_W-1:0];
      n_hi = N_LO_W'(mid_end.n >> N_LO_W);
      n_lo = mid_end.n[N_LO_W-1:0];
      sf_hh_in = MP_W'(chord_hi) * MP_W'(n_hi);
      sf_hl_in = MP_W'(chord_hi) * MP_W'(n_lo);
      sf_lh_in = MP_W'(chord_lo) * MP_W'(n_hi);
      sf_ll_in = MP_W'(chord_lo) * MP_W'(n_lo);
      sf_tail_in.den = mid_end.den;
      sf_tail_in.flags = mid_end.flags;
      sf_tail_in.flags.chord_zero = (chord == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) sf_valid_ff <= 1'b0;
      else sf_valid_ff <= rt_valid[MAG_W];
      sf_tail_ff <= sf_tail_in;
      sf_hh_ff <= sf_hh_in;
      sf_hl_ff <= sf_hl_in;
      sf_lh_ff <= sf_lh_in;
      sf_ll_ff <= sf_ll_in;
   end

   // Stage G: full product.
   logic              sg_valid_ff;
   tail_type          sg_tail_ff;
   logic [PROD_W-1:0] sg_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) sg_valid_ff <= 1'b0;
      else sg_valid_ff <= sf_valid_ff;
      sg_tail_ff <= sf_tail_ff;
      sg_prod_ff <= (PROD_W'(sf_hh_ff) << (HALF_W + N_LO_W)) + (PROD_W'(sf_hl_ff) << HALF_W)
                  + (PROD_W'(sf_lh_ff) << N_LO_W) + PROD_W'(sf_ll_ff);
   end

   // Stage H: a quotient of 2^32 or more saturates; otherwise the upper part of the
   // product is the starting remainder of the divider row.
   logic [CMP_W-1:0] upper_ext, den_ext;
   logic     sh_valid_ff;
   div_type  sh_div_ff, sh_div_in;
   tail_type sh_tail_ff, sh_tail_in;

   always_comb begin
      upper_ext = CMP_W'(sg_prod_ff[PROD_W-1:Q_W]);
      den_ext = CMP_W'(sg_tail_ff.den);
      sh_tail_in = sg_tail_ff;
      sh_tail_in.flags.ovf = upper_ext >= den_ext;
      sh_div_in.rem = upper_ext[DEN_W-1:0];
      sh_div_in.low_bits = sg_prod_ff[Q_W-1:0];
      sh_div_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) sh_valid_ff <= 1'b0;
      else sh_valid_ff <= sg_valid_ff;
      sh_div_ff <= sh_div_in;
      sh_tail_ff <= sh_tail_in;
   end

   logic     dv_valid [Q_W+1];
   div_type  dv_div [Q_W+1];
   tail_type dv_tail [Q_W+1];

   assign dv_valid[0] = sh_valid_ff;
   assign dv_div[0] = sh_div_ff;
   assign dv_tail[0] = sh_tail_ff;

   for (genvar i = 0; i < Q_W; i++) begin : g_div
      cacr_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (dv_valid[i]),
         .in_div   (dv_div[i]),
         .in_tail  (dv_tail[i]),
         .out_valid(dv_valid[i+1]),
         .out_div  (dv_div[i+1]),
         .out_tail (dv_tail[i+1])
      );
   end

   // Output register. The special cases are ranked as the angle check first,
   // then a zero chord, then the saturating cases.
   flag_type fin_flags;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff, rsp_in;

   always_comb begin
      fin_flags = dv_tail[Q_W].flags;
      rsp_in.radius = '1;
      if (fin_flags.undef) begin
         rsp_in.status = ST_UNDEF;
      end else if (fin_flags.chord_zero) begin
         rsp_in.status = ST_VALID;
         rsp_in.radius = '0;
      end else if (fin_flags.neg || fin_flags.ab_zero || fin_flags.ovf) begin
         rsp_in.status = ST_SAT;
      end else begin
         rsp_in.status = ST_VALID;
         rsp_in.radius = dv_div[Q_W].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= dv_valid[Q_W];
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ hw/rtl/cacr_cordic_cell.sv @@
// One rotation step of the half-angle CORDIC, registered, with the item's other
// data riding along.
// Depends on cacr_pkg.
module cacr_cordic_cell import cacr_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  cordic_type in_rot,
   input  front_type  in_front,
   output logic       out_valid,
   output cordic_type out_rot,
   output front_type  out_front
);

   localparam logic signed [CS_W-1:0] ATAN_STEP = atan_q29(STAGE);

   logic       valid_ff;
   cordic_type rot_ff, rot_in;
   front_type  front_ff;
   logic signed [CS_W-1:0] x_sh, y_sh;

   always_comb begin
      x_sh = in_rot.x >>> STAGE;
      y_sh = in_rot.y >>> STAGE;
      if (!in_rot.z[CS_W-1]) begin
         rot_in.x = in_rot.x - y_sh;
         rot_in.y = in_rot.y + x_sh;
         rot_in.z = in_rot.z - ATAN_STEP;
      end else begin
         rot_in.x = in_rot.x + y_sh;
         rot_in.y = in_rot.y - x_sh;
         rot_in.z = in_rot.z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      rot_ff <= rot_in;
      front_ff <= in_front;
   end

   assign out_valid = valid_ff;
   assign out_rot = rot_ff;
   assign out_front = front_ff;

endmodule

@@ hw/rtl/cacr_root_cell.sv @@
// One bit of the restoring integer square root of the chord length squared.
// Depends on cacr_pkg.
module cacr_root_cell import cacr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  root_type in_root,
   input  mid_type  in_mid,
   output logic     out_valid,
   output root_type out_root,
   output mid_type  out_mid
);

   logic     valid_ff;
   root_type root_ff, root_in;
   mid_type  mid_ff;
   logic [ROOT_REM_W-1:0] shifted, trial;
   logic                  fits;

   always_comb begin
      shifted = {in_root.rem[ROOT_REM_W-3:0], in_root.rad[SQ_W-1 -: 2]};
      trial = ROOT_REM_W'({in_root.root, 2'b01});
      fits = shifted >= trial;
      root_in.rem = fits ? shifted - trial : shifted;
      root_in.root = {in_root.root[MAG_W-2:0], fits};
      root_in.rad = {in_root.rad[SQ_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      root_ff <= root_in;
      mid_ff <= in_mid;
   end

   assign out_valid = valid_ff;
   assign out_root = root_ff;
   assign out_mid = mid_ff;

endmodule

@@ hw/rtl/cacr_div_cell.sv @@
// One quotient bit of the restoring division that forms the radius.
// Depends on cacr_pkg.
module cacr_div_cell import cacr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  div_type  in_div,
   input  tail_type in_tail,
   output logic     out_valid,
   output div_type  out_div,
   output tail_type out_tail
);

   logic     valid_ff;
   div_type  div_ff, div_in;
   tail_type tail_ff;
   logic [DEN_W:0] shifted, diff;
   logic           fits;

   always_comb begin
      shifted = {in_div.rem, in_div.low_bits[Q_W-1]};
      diff = shifted - {1'b0, in_tail.den};
      fits = shifted >= {1'b0, in_tail.den};
      div_in.rem = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      div_in.low_bits = {in_div.low_bits[Q_W-2:0], 1'b0};
      div_in.quo = {in_div.quo[Q_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      div_ff <= div_in;
      tail_ff <= in_tail;
   end

   assign out_valid = valid_ff;
   assign out_div = div_ff;
   assign out_tail = tail_ff;

endmodule

@@ hw/rtl/cacr_checker.sv @@
// Port-level checks of the chord-angle circle radius block, bound to its top level.
// Depends on cacr_pkg and chord_angle_circle_radius.
module cacr_checker import cacr_pkg::*; #(
   parameter int LATENCY = 1
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Reset drops every word in flight.
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word after reset");

   // Every result word comes from an input word that the block took earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result word without a matching input word");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_VALID || rsp_data.status == ST_UNDEF
                     || rsp_data.status == ST_SAT))
      else $error("unknown status code");

   // Undefined and saturated results carry an all-ones radius.
   a_flag_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_VALID) |-> (rsp_data.radius == '1))
      else $error("flagged result without all-ones radius");

endmodule

bind chord_angle_circle_radius cacr_checker #(.LATENCY(LATENCY)) u_cacr_checker (.*);

@@ tb/sv/chord_angle_circle_radius_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chord_angle_circle_radius: point-pair words in, radius words out.
// Depends on cacr_pkg and the block's RTL; predicts every result and checks it in order.

import cacr_pkg::*;

// Holds the configuration as the block sees it and the radius words still to come.
class radius_scoreboard;
   logic [WIDTH_PX_W-1:0] width_px;
   logic [FOV_W-1:0]      fov;
   logic [OFFSET_W-1:0]   offset_px;
   rsp_type               pending[$];
   int                    errors;

   function new();
      width_px = '0;
      fov = '0;
      offset_px = '0;
      errors = 0;
   endfunction

   // atan(2^-i) in Q2.29, rounded to nearest.
   function longint angle_step(int i);
      longint tab[11];
      tab = '{421657428, 248918915, 131521918, 66762579, 33510843,
              16771758, 8387925, 4194219, 2097141, 1048575, 524288};
      if (i < 11) return tab[i];
      if (i <= 29) return longint'(1) << (29 - i);
      return 0;
   endfunction

   function rsp_type radius_of(req_type r);
      rsp_type       res;
      logic [14:0]   d;
      longint        theta, x, y, z, xs, ys, c, s, ddx, ddz;
      bit            flip;
      logic [127:0]  sq, q, dx, dz;
      logic [63:0]   root, cand, a, b, n, den;
      res.radius = '1;
      res.status = ST_VALID;
      d = offset_px[OFFSET_W-1] ? 15'(15'd16384 - offset_px) : 15'(offset_px);
      if (width_px == 0 || d == 0 || fov == 0) begin
         res.status = ST_UNDEF;
         return res;
      end
      theta = longint'(fov) * 32768;
      flip = theta > 843314857;
      if (flip) theta = 1686629713 - theta;
      x = longint'(1) << 29;
      y = 0;
      z = theta;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= angle_step(i);
         end else begin
            x += ys; y -= xs; z += angle_step(i);
         end
      end
      c = flip ? -x : x;
      s = y;
      if (c == 0 || s == 0) begin
         res.status = ST_UNDEF;
         return res;
      end
      ddx = longint'($signed(r.first_x)) - longint'($signed(r.second_x));
      ddz = longint'($signed(r.first_z)) - longint'($signed(r.second_z));
      dx = (ddx < 0) ? -ddx : ddx;
      dz = (ddz < 0) ? -ddz : ddz;
      sq = dx * dx + dz * dz;
      root = '0;
      for (int k = 63; k >= 0; k--) begin
         cand = root | (64'd1 << k);
         if ({64'd0, cand} * {64'd0, cand} <= sq) root = cand;
      end
      if (root == 0) begin
         res.radius = '0;
         return res;
      end
      if (c < 0 || s < 0) begin
         res.status = ST_SAT;
         return res;
      end
      a = 64'(width_px) * 64'(c);
      b = 64'(d) * 64'(s);
      while (((a | b) >> 31) != 0) begin
         a >>= 1;
         b >>= 1;
      end
      if (a == 0 || b == 0) begin
         res.status = ST_SAT;
         return res;
      end
      n = a * a + b * b;
      den = 4 * a * b;
      q = ({64'd0, root} * {64'd0, n}) / {64'd0, den};
      if ((q >> 32) != 0) res.status = ST_SAT;
      else res.radius = q[31:0];
      return res;
   endfunction

   function void note_word(req_type r);
      pending.push_back(radius_of(r));
   endfunction

   function void check_word(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         $error("radius word with none expected: radius %h status %0d", got.radius, got.status);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.radius !== want.radius) begin
         $error("radius: expected %h, got %h", want.radius, got.radius);
         errors++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
   endfunction
endclass

module chord_angle_circle_radius_test;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = REG_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   radius_scoreboard sb = new();

   chord_angle_circle_radius i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Observe both channels at the clock edge. Inputs change only by nonblocking
   // assignment at this same edge, so the values read here are the ones the block
   // itself sampled. Configuration updates are mirrored here too, so the predictor
   // always uses the register values that were in force when a word was taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH:  sb.width_px = csr_data[WIDTH_PX_W-1:0];
               REG_FOV:    sb.fov = csr_data[FOV_W-1:0];
               REG_OFFSET: sb.offset_px = csr_data[OFFSET_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) sb.note_word(req_data);
         if (rsp_valid) sb.check_word(rsp_data);
      end
   end

   // Hand one word to the block. start is left high afterward so that back-to-back
   // words in a burst never drop it in between; idle_for lowers it.
   task automatic send_word(input req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Registers may only change with nothing in flight. Every word produces a
   // result, so an empty queue means the pipeline is drained; the wait after
   // that is a further margin.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_view(input int w, input int f, input int o);
      drain();
      write_reg(REG_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_FOV, CSR_DATA_W'(f));
      write_reg(REG_OFFSET, CSR_DATA_W'(o & 16'h3fff));
   endtask

   function automatic req_type make_pair(input logic signed [31:0] ax, input logic signed [31:0] az,
                                         input logic signed [31:0] bx, input logic signed [31:0] bz);
      req_type r;
      r.first_x = ax;
      r.first_z = az;
      r.second_x = bx;
      r.second_z = bz;
      return r;
   endfunction

   // Mostly realistic ground points a few metres apart, plus full-range noise,
   // coincident points and coordinate extremes.
   function automatic req_type random_pair();
      logic signed [31:0] ax, az;
      int kind;
      kind = $urandom_range(0, 9);
      ax = $signed($urandom_range(0, 32'h007f_ffff)) - 32'sh0040_0000;
      az = $signed($urandom_range(0, 32'h007f_ffff)) - 32'sh0040_0000;
      case (kind)
         0, 1: return make_pair($urandom, $urandom, $urandom, $urandom);
         8: return make_pair(ax, az, ax, az);
         9: return make_pair($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000,
                             $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000,
                             $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000,
                             $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000);
         default: return make_pair(ax, az,
                                   ax + $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000,
                                   az + $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
      endcase
   endfunction

   // Words go out in bursts of random length; some gaps are zero so that long
   // stretches run at full rate.
   task automatic random_words(input int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && left > 0; k++) begin
            send_word(random_pair());
            left--;
         end
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 7));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Registers still at their reset value of zero: every result is undefined.
      random_words(20);

      // Directed words under a typical camera setup.
      set_view(1920, 9830, 300);
      send_word(make_pair(0, 0, 0, 0));
      send_word(make_pair(32'sh0001_0000, 0, 0, 0));
      send_word(make_pair(0, 32'sh0001_0000, 0, 0));
      send_word(make_pair(1, 0, 0, 0));
      send_word(make_pair(32'sh0003_0000, 32'sh0004_0000, 0, 0));
      send_word(make_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000));
      send_word(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
      send_word(make_pair(32'sh7fff_ffff, 0, 32'sh7fff_ffff, 0));
      send_word(make_pair(-32'sh0002_0000, 32'sh0005_0000, 32'sh0002_0000, -32'sh0005_0000));
      send_word(make_pair(32'shffff_ffff, 32'shffff_ffff, 0, 0));
      send_word(make_pair(32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555));
      send_word(make_pair(32'sh0000_0100, 32'sh0000_0200, 32'sh0000_0100, 32'sh0000_0201));
      idle_for(1);

      // Extremes of the view settings: zero width and zero offset are undefined;
      // a field of view beyond pi/2 drives the cosine negative; tiny and huge
      // ratios push the radius into saturation.
      set_view(0, 9830, 300);       random_words(30);
      set_view(1920, 9830, 0);      random_words(30);
      set_view(1, 1, 1);            random_words(40);
      set_view(8191, 25736, -8191); random_words(60);
      set_view(8191, 32767, -8192); random_words(60);
      set_view(1, 25735, 8191);     random_words(60);
      set_view(8191, 1, 1);         random_words(40);
      set_view(1, 32767, -1);       random_words(40);
      set_view(640, 12868, -320);   random_words(80);
      set_view(640, 12869, 320);    random_words(80);

      // Random camera setups, mostly realistic, now and then anywhere in range.
      for (int p = 0; p < 10; p++) begin
         if ($urandom_range(0, 2) == 0)
            set_view($urandom_range(0, 8191), $urandom_range(0, 32767),
                     int'($urandom_range(0, 16383)) - 8192);
         else
            set_view($urandom_range(320, 4096), $urandom_range(1, 25736),
                     int'($urandom_range(0, 4000)) - 2000);
         random_words(110);
      end

      drain();
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Backstop for a block that stops answering.
   initial begin
      #(8 * 1000000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
